// File: hw/rtl/flash_record_table_with_tombstones_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef FLASH_RECORD_TABLE_WITH_TOMBSTONES_MACROS_SVH
`define FLASH_RECORD_TABLE_WITH_TOMBSTONES_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/frt_pkg.sv
package frt_pkg;

    // Identifier bytes kept per slot.
    localparam int UID_MAX_BYTES = 8;

    // Saturation limit of the 7-bit count and index fields.
    localparam logic [6:0] SAT_MAX = 7'd127;

    // Request codes.
    localparam logic [2:0] ACT_COUNT  = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_ADD    = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;
    localparam logic [2:0] ACT_ERASE  = 3'd4;
    localparam logic [2:0] ACT_FIND   = 3'd5;

    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_ACTIVE,
        SLOT_DELETED
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] uid;
        logic [7:0]  uid_len;
        logic [63:0] pay_lo;
        logic [63:0] pay_hi;
    } t_body;

    typedef struct packed {
        t_status status;
        t_body   body;
    } t_slot;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  slot_index;
        logic [63:0] uid;
        logic [3:0]  uid_len;
        logic [63:0] pay_lo;
        logic [63:0] pay_hi;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [6:0]  active_count;
        logic [6:0]  found_index;
        t_body       rd;
    } t_rsp;

    // Contents of an erased slot.
    localparam t_body BODY_ERASED = '{uid: '1, uid_len: '1, pay_lo: '1, pay_hi: '1};

    // Mask covering the low nbytes bytes of a 64-bit word.
    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nbytes) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [63:0] UID_MASK = byte_mask(4'(UID_MAX_BYTES));

endpackage

// File: hw/rtl/frt_if.sv
interface frt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [5:0]  slot_index;
    logic [63:0] uid_bytes;
    logic [3:0]  uid_length;
    logic [63:0] payload_low;
    logic [63:0] payload_high;

    modport source (
        output valid, action, slot_index, uid_bytes, uid_length, payload_low, payload_high,
        input  ready
    );
    modport sink (
        input  valid, action, slot_index, uid_bytes, uid_length, payload_low, payload_high,
        output ready
    );
endinterface

interface frt_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [6:0]  active_count;
    logic [6:0]  found_index;
    logic [63:0] read_uid;
    logic [7:0]  read_uid_length;
    logic [63:0] read_payload_low;
    logic [63:0] read_payload_high;

    modport source (
        output valid, ok, active_count, found_index, read_uid, read_uid_length,
               read_payload_low, read_payload_high,
        input  ready
    );
    modport sink (
        input  valid, ok, active_count, found_index, read_uid, read_uid_length,
               read_payload_low, read_payload_high,
        output ready
    );
endinterface

// File: hw/rtl/frt_cell.sv
// One slot of the ring; takes its neighbour's slot on every shift.
module frt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  frt_pkg::t_slot i_slot,
    output frt_pkg::t_slot o_slot
);
    import frt_pkg::*;

    t_status r_status;
    t_body   r_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= SLOT_EMPTY;
        end else if (i_shift) begin
            r_status <= i_slot.status;
        end
    end

    // Data of an empty slot is never looked at, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_body <= i_slot.body;
        end
    end

    assign o_slot.status = r_status;
    assign o_slot.body   = r_body;

endmodule

// File: hw/rtl/frt_head.sv
// Update point of the ring: sees one slot per step, rewrites it and
// gathers the result of the request.
module frt_head #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_start,
    input  logic                              i_advance,
    input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] i_step,
    input  frt_pkg::t_req                     i_req,
    input  frt_pkg::t_slot                    i_slot,
    output frt_pkg::t_slot                    o_slot,
    output frt_pkg::t_rsp                     o_rsp
);
    import frt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = (IDX_W > 6) ? IDX_W : 6;
    localparam int SAT_W = (IDX_W > 7) ? IDX_W : 7;
    localparam logic [6:0] FOUND_NONE = (SLOT_COUNT > 127) ? SAT_MAX : 7'(SLOT_COUNT);

    logic        r_hit;
    logic [6:0]  r_count;
    logic [6:0]  r_found;
    t_body       r_rd;

    logic        n_hit;
    logic [6:0]  n_count;
    logic [6:0]  n_found;
    t_body       n_rd;

    logic        at_index;
    logic        is_active;
    logic        is_empty;
    logic [3:0]  cmp_len;
    logic [63:0] find_mask;
    logic        uid_match;
    logic [SAT_W-1:0] step_wide;
    logic [6:0]  step_sat;

    always_comb begin
        at_index  = (CMP_W'(i_req.slot_index) == CMP_W'(i_step));
        is_active = (i_slot.status == SLOT_ACTIVE);
        is_empty  = (i_slot.status == SLOT_EMPTY);
        cmp_len   = (i_req.uid_len < 4'(UID_MAX_BYTES)) ? i_req.uid_len : 4'(UID_MAX_BYTES);
        find_mask = byte_mask(cmp_len);
        uid_match = (((i_slot.body.uid ^ i_req.uid) & find_mask) == 64'd0);
        step_wide = SAT_W'(i_step);
        step_sat  = (step_wide > SAT_W'(SAT_MAX)) ? SAT_MAX : step_wide[6:0];

        o_slot  = i_slot;
        n_hit   = r_hit;
        n_count = r_count;
        n_found = r_found;
        n_rd    = r_rd;

        case (i_req.action)
            ACT_COUNT: begin
                if (is_active && (r_count != SAT_MAX)) begin
                    n_count = r_count + 7'd1;
                end
            end
            ACT_READ: begin
                if (at_index) begin
                    n_hit = is_active;
                    n_rd  = is_empty ? BODY_ERASED : i_slot.body;
                end
            end
            ACT_ADD: begin
                // first empty slot only; tombstones stay
                if (is_empty && !r_hit) begin
                    o_slot.status      = SLOT_ACTIVE;
                    o_slot.body.uid    = i_req.uid & UID_MASK;
                    o_slot.body.uid_len = 8'(i_req.uid_len);
                    o_slot.body.pay_lo = i_req.pay_lo;
                    o_slot.body.pay_hi = i_req.pay_hi;
                    n_hit              = 1'b1;
                end
            end
            ACT_DELETE: begin
                if (at_index && is_active) begin
                    o_slot.status = SLOT_DELETED;
                    n_hit         = 1'b1;
                end
            end
            ACT_ERASE: begin
                o_slot.status = SLOT_EMPTY;
            end
            ACT_FIND: begin
                if (!r_hit && is_active && uid_match &&
                    (i_slot.body.uid_len == 8'(i_req.uid_len))) begin
                    n_hit   = 1'b1;
                    n_found = step_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hit   <= 1'b0;
            r_count <= 7'd0;
            r_found <= FOUND_NONE;
            r_rd    <= '0;
        end else if (i_advance) begin
            r_hit   <= n_hit;
            r_count <= n_count;
            r_found <= n_found;
            r_rd    <= n_rd;
        end
    end

    always_comb begin
        o_rsp = '0;
        o_rsp.rd = r_rd;
        case (i_req.action)
            ACT_COUNT: begin
                o_rsp.ok           = 1'b1;
                o_rsp.active_count = r_count;
            end
            ACT_READ, ACT_ADD, ACT_DELETE: begin
                o_rsp.ok = r_hit;
            end
            ACT_ERASE: begin
                o_rsp.ok = 1'b1;
            end
            ACT_FIND: begin
                o_rsp.ok          = 1'b1;
                o_rsp.found_index = r_found;
            end
            default: begin
                o_rsp.ok = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/flash_record_table_with_tombstones.sv
// Channel   Dir  Handshake      Carries
// i_req     in   valid/ready    action, slot_index, uid_bytes, uid_length, payload_low/high
// o_rsp     out  valid/ready    ok, active_count, found_index, read_uid, read fields
//
// Each request runs alone from its acceptance until the next acceptance:
// the slot ring makes one full turn past the update head, one slot per cycle.
// After the turn the result is registered for o_rsp before the next request is taken.
// Reset clears every slot status to empty; no clearing pass.
// A full result register holds the block after the turn until o_rsp drains;
// a new request may be taken while the previous result still waits.
`include "flash_record_table_with_tombstones_macros.svh"

module flash_record_table_with_tombstones #(
    parameter int SLOT_COUNT = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    frt_req_if.sink         i_req,
    frt_rsp_if.source       o_rsp
);
    import frt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOT_COUNT - 1);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_step;
    logic [IDX_W-1:0] n_step;
    t_req             r_req;
    t_rsp             r_rsp;
    logic             r_out_valid;
    logic             n_out_valid;

    logic  accept;
    logic  shift;
    logic  load_out;
    t_slot head_slot;
    t_rsp  head_rsp;
    t_slot ring [SLOT_COUNT];
    t_slot feed [SLOT_COUNT];

    // Take a new request only between turns of the ring, never during reset.
    assign i_req.ready = i_rst_n && (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        shift       = 1'b0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && !o_rsp.ready;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                    n_step  = '0;
                end
            end
            ST_SCAN: begin
                // advance the ring by one slot; slot r_step sits at the head
                shift  = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || o_rsp.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Capture the request; it stays put for the whole turn.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.action     <= i_req.action;
            r_req.slot_index <= i_req.slot_index;
            r_req.uid        <= i_req.uid_bytes;
            r_req.uid_len    <= i_req.uid_length;
            r_req.pay_lo     <= i_req.payload_low;
            r_req.pay_hi     <= i_req.payload_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_rsp <= head_rsp;
        end
    end

    // Slot ring: cell 0 is the head, the head's rewritten slot re-enters at the tail.
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        if (k == SLOT_COUNT - 1) begin : g_tail
            assign feed[k] = head_slot;
        end else begin : g_link
            assign feed[k] = ring[k+1];
        end
        frt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_slot  (feed[k]),
            .o_slot  (ring[k])
        );
    end

    frt_head #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_head (
        .i_clk     (i_clk),
        .i_start   (accept),
        .i_advance (shift),
        .i_step    (r_step),
        .i_req     (r_req),
        .i_slot    (ring[0]),
        .o_slot    (head_slot),
        .o_rsp     (head_rsp)
    );

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.ok                = r_rsp.ok;
    assign o_rsp.active_count      = r_rsp.active_count;
    assign o_rsp.found_index       = r_rsp.found_index;
    assign o_rsp.read_uid          = r_rsp.rd.uid;
    assign o_rsp.read_uid_length   = r_rsp.rd.uid_len;
    assign o_rsp.read_payload_low  = r_rsp.rd.pay_lo;
    assign o_rsp.read_payload_high = r_rsp.rd.pay_hi;

    `FRT_ASSERT_NEXT(a_turn_starts, i_clk, i_rst_n, accept, (r_state == ST_SCAN) && (r_step == '0), "turn does not start at slot zero")
    `FRT_ASSERT_NEXT(a_turn_ends, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_step == LAST_STEP), r_state == ST_DONE, "turn does not end after the last slot")
    `FRT_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_rsp.valid && (o_rsp.found_index != 7'd0), o_rsp.ok, "found index given without success")

endmodule
